// File: rtl/lfr_pkg.sv
`timescale 1ns / 1ps

package lfr_pkg;

	// Longest search or replacement pattern held by the block
	localparam int MAX_PATTERN = 32;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

	// Field widths of the beats
	localparam int SLOT_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 2;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_LOAD_SEARCH = 2'd0,
		OP_LOAD_REPL   = 2'd1,
		OP_LINE_BYTE   = 2'd2,
		OP_END_LINE    = 2'd3
	} op_t;

	// Closing status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_EMPTY     = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH = 2'd2;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [BYTE_W-1:0] data_byte;
	} src_t;

	typedef struct packed {
		logic               byte_valid;
		logic [BYTE_W-1:0]  out_byte;
		logic               line_done;
		logic [COUNT_W-1:0] match_count;
		logic [1:0]         status;
		logic               last;
	} dst_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic wr_search;  // load the search byte of this cell
		logic load_here;  // incoming line byte lands in this cell
		logic shift;      // take the right neighbor's byte
		logic in_use;     // cell lies inside the search pattern
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPL,
		ST_FLUSH
	} state_t;

endpackage

// File: rtl/lfr_cell.sv
`timescale 1ns / 1ps

module lfr_cell (
	input  logic                     clk,
	input  lfr_pkg::cell_ctl_t       ctl,
	input  logic [lfr_pkg::BYTE_W-1:0] din,
	input  logic [lfr_pkg::BYTE_W-1:0] right_view,
	output logic [lfr_pkg::BYTE_W-1:0] view,
	output logic                     eq
);
	import lfr_pkg::*;

	logic [BYTE_W-1:0] search_q;
	logic [BYTE_W-1:0] win_q;

	// Byte this cell holds once the incoming line byte is placed
	assign view = ctl.load_here ? din : win_q;
	assign eq   = !ctl.in_use || (view == search_q);

	// Search byte and window byte
	always_ff @(posedge clk) begin
		if (ctl.wr_search) begin
			search_q <= din;
		end
		if (ctl.shift) begin
			win_q <= right_view;
		end else if (ctl.load_here) begin
			win_q <= din;
		end
	end

endmodule

// File: rtl/lfr_out_buf.sv
`timescale 1ns / 1ps

module lfr_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lfr_pkg::dst_t push_data,
	output logic          full,
	output logic          dst_valid,
	input  logic          dst_stall,
	output lfr_pkg::dst_t dst_data
);
	import lfr_pkg::*;

	dst_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign dst_valid = (count_q != 2'd0);
	assign dst_data  = slot_q[rd_ptr_q];
	assign pop       = dst_valid && !dst_stall;

	// Beat storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("beat pushed into full output buffer");

	count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");

	pop_frees_space: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !dst_stall) |=> !full)
		else $error("output buffer stayed full after a pop");

endmodule

// File: rtl/line_find_and_replace.sv
`timescale 1ns / 1ps
// Timing: a beat pushed when an input beat is accepted can be taken at dst in the cycle after;
//   the first beat of an end of line passes the sequencer state, then the output buffer.
// Throughput: one line byte per cycle while the output buffer has room; a hit stalls the input
//   for replacement bytes past the first, end of line for each held window byte and the close.
// Reset (arst_n low, asynchronous) clears sequencer, counters, fill and config registers;
//   search and replacement bytes are undefined until loaded.

module line_find_and_replace (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  lfr_pkg::src_t                   src_data,
	output logic                            dst_valid,
	input  logic                            dst_stall,
	output lfr_pkg::dst_t                   dst_data,
	input  logic                            cfg_write_en,
	input  logic [lfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfr_pkg::CFG_W-1:0]       cfg_data
);
	import lfr_pkg::*;

	state_t             state_q, state_d;
	logic               global_q;
	logic [LEN_W-1:0]   mlen_q, rlen_q;
	logic [LEN_W-1:0]   fill_q, fill_d;
	logic               replaced_q, replaced_d;
	logic [COUNT_W-1:0] hits_q, hits_d;
	logic [IDX_W-1:0]   rep_idx_q, rep_idx_d;
	logic [BYTE_W-1:0]  rep_mem_q [MAX_PATTERN];

	logic [LEN_W-1:0]   m_len, r_len, fill_pos;
	logic               acc, go, buf_full, window_full, hit, allowed, rep_last;
	logic               push;
	dst_t               push_data;
	logic [IDX_W-1:0]   rep_rd_idx;
	logic [BYTE_W-1:0]  rep_byte;

	cell_ctl_t          cell_ctl [MAX_PATTERN];
	logic [BYTE_W-1:0]  view [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;

	// Clamped lengths and append position
	assign m_len    = (mlen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : mlen_q;
	assign r_len    = (rlen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : rlen_q;
	assign fill_pos = (fill_q >= m_len) ? (m_len - LEN_W'(1)) : fill_q;
	assign window_full = (fill_pos == m_len - LEN_W'(1));

	assign go        = !buf_full;
	assign src_stall = (state_q != ST_IDLE) || !go;
	assign acc       = src_valid && !src_stall;
	assign allowed   = global_q || !replaced_q;
	assign hit       = allowed && (&eq);

	// Replacement byte read
	assign rep_rd_idx = (state_q == ST_IDLE) ? '0 : rep_idx_q;
	assign rep_byte   = rep_mem_q[rep_rd_idx];
	assign rep_last   = ({1'b0, rep_rd_idx} + LEN_W'(1)) == r_len;

	// Window cells
	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		logic [BYTE_W-1:0] right;
		if (g == MAX_PATTERN - 1) begin : g_end
			assign right = '0;
		end else begin : g_mid
			assign right = view[g+1];
		end
		lfr_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.din        (src_data.data_byte),
			.right_view (right),
			.view       (view[g]),
			.eq         (eq[g])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && src_data.op == OP_LINE_BYTE && m_len != '0 && window_full
						&& hit && r_len > LEN_W'(1)) begin
					state_d = ST_REPL;
				end else if (acc && src_data.op == OP_END_LINE) begin
					state_d = ST_FLUSH;
				end
			end
			ST_REPL: begin
				if (go && rep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (go && fill_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: cell control, result beat, counter updates
	always_comb begin
		logic line_acc;
		logic drop_oldest;
		line_acc    = acc && src_data.op == OP_LINE_BYTE && m_len != '0;
		drop_oldest = 1'b0;
		push        = 1'b0;
		push_data   = '0;
		fill_d      = fill_q;
		replaced_d  = replaced_q;
		hits_d      = hits_q;
		rep_idx_d   = rep_idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (acc && src_data.op == OP_LINE_BYTE && m_len == '0) begin
					push                 = 1'b1;
					push_data.byte_valid = 1'b1;
					push_data.out_byte   = src_data.data_byte;
					push_data.last       = 1'b1;
				end else if (line_acc && !window_full) begin
					fill_d = fill_pos + LEN_W'(1);
				end else if (line_acc && hit) begin
					fill_d     = '0;
					replaced_d = 1'b1;
					if (hits_q != '1) begin
						hits_d = hits_q + COUNT_W'(1);
					end
					rep_idx_d = IDX_W'(1);
					if (r_len != '0) begin
						push                 = 1'b1;
						push_data.byte_valid = 1'b1;
						push_data.out_byte   = rep_byte;
						push_data.last       = rep_last;
					end
				end else if (line_acc) begin
					drop_oldest          = 1'b1;
					fill_d               = fill_pos;
					push                 = 1'b1;
					push_data.byte_valid = 1'b1;
					push_data.out_byte   = view[0];
					push_data.last       = 1'b1;
				end
			end
			ST_REPL: begin
				if (go) begin
					push                 = 1'b1;
					push_data.byte_valid = 1'b1;
					push_data.out_byte   = rep_byte;
					push_data.last       = rep_last;
					rep_idx_d            = rep_idx_q + IDX_W'(1);
				end
			end
			ST_FLUSH: begin
				if (go && fill_q != '0) begin
					drop_oldest          = 1'b1;
					fill_d               = fill_q - LEN_W'(1);
					push                 = 1'b1;
					push_data.byte_valid = 1'b1;
					push_data.out_byte   = view[0];
				end else if (go) begin
					push                  = 1'b1;
					push_data.line_done   = 1'b1;
					push_data.match_count = (m_len == '0) ? '0 : hits_q;
					if (m_len == '0) begin
						push_data.status = STATUS_EMPTY;
					end else if (hits_q == '0) begin
						push_data.status = STATUS_NOT_FOUND;
					end else begin
						push_data.status = STATUS_OK;
					end
					push_data.last = 1'b1;
					fill_d         = '0;
					replaced_d     = 1'b0;
					hits_d         = '0;
				end
			end
			default: ;
		endcase

		for (int i = 0; i < MAX_PATTERN; i++) begin
			cell_ctl[i].wr_search = acc && src_data.op == OP_LOAD_SEARCH
				&& src_data.slot == SLOT_W'(i);
			cell_ctl[i].load_here = line_acc && fill_pos == LEN_W'(i);
			cell_ctl[i].shift     = drop_oldest;
			cell_ctl[i].in_use    = LEN_W'(i) < m_len;
		end
	end

	// Replacement pattern store
	always_ff @(posedge clk) begin
		if (acc && src_data.op == OP_LOAD_REPL) begin
			rep_mem_q[src_data.slot] <= src_data.data_byte;
		end
	end

	// Sequencer, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			global_q   <= 1'b0;
			mlen_q     <= '0;
			rlen_q     <= '0;
			fill_q     <= '0;
			replaced_q <= 1'b0;
			hits_q     <= '0;
			rep_idx_q  <= '0;
		end else begin
			state_q    <= state_d;
			replaced_q <= replaced_d;
			hits_q     <= hits_d;
			rep_idx_q  <= rep_idx_d;
			// a new search length empties the window
			if (cfg_write_en && cfg_index == CFG_MATCH_LENGTH) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_d;
			end
			if (cfg_write_en) begin
				unique case (cfg_index)
					CFG_GLOBAL_MODE:    global_q <= cfg_data[0];
					CFG_MATCH_LENGTH:   mlen_q <= cfg_data;
					CFG_REPLACE_LENGTH: rlen_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	lfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (buf_full),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(MAX_PATTERN))
		else $error("window fill beyond pattern store");

	accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> state_q == ST_IDLE)
		else $error("input accepted while sequencer busy");

	repl_index_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REPL |-> ({1'b0, rep_idx_q} < r_len))
		else $error("replacement index past replacement length");

	close_clears_line: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.line_done) |=> (hits_q == '0 && !replaced_q
			&& state_q == ST_IDLE))
		else $error("line state not cleared after close");

endmodule
